FILE: rtl/core/canonical_kmer_key_stream_core_macros.svh
// Assertion macros shared by the k-mer key stream core.
// Assertions are left out when NO_ASSERTIONS is set.
`ifndef CANONICAL_KMER_KEY_STREAM_CORE_MACROS_SVH
`define CANONICAL_KMER_KEY_STREAM_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define KKEY_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define KKEY_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define KKEY_ASSERT(lbl, clk, rstn, prop, msg)
`define KKEY_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

FILE: rtl/core/kkey_pkg.sv
// Types and constants for the k-mer key stream core.
// No dependencies.
`default_nettype none
package kkey_pkg;

  localparam logic [1:0] CFG_KLEN = 2'd0;
  localparam logic [1:0] CFG_MOD  = 2'd1;
  localparam logic [1:0] CFG_BIS  = 2'd2;

  localparam logic [1:0] BIS_C2T = 2'd1;
  localparam logic [1:0] BIS_G2A = 2'd2;

  localparam logic [7:0] BYTE_NL    = 8'd10;
  localparam logic [7:0] BYTE_HDR   = 8'h3E;
  localparam logic [7:0] BYTE_PRINT = 8'd33;

  localparam logic [2:0] CODE_A = 3'd0;
  localparam logic [2:0] CODE_C = 3'd1;
  localparam logic [2:0] CODE_G = 3'd2;
  localparam logic [2:0] CODE_T = 3'd3;
  localparam logic [2:0] CODE_N = 3'd4;

  localparam int unsigned WIN_W = 64;
  localparam int unsigned MOD_W = 33;
  localparam int unsigned KEY_W = 32;

  typedef struct packed {
    logic [5:0] klen;
    logic [1:0] mode;
  } cfg_t;

  typedef struct packed {
    logic [WIN_W-1:0] canon;
    logic             fwd;
    logic [KEY_W-1:0] start;
  } job_t;

endpackage
`default_nettype wire

FILE: rtl/core/kkey_front.sv
// Front end: parses text bytes, rolls the k-mer windows, issues k-mer jobs.
// Depends on kkey_pkg.
`default_nettype none
module kkey_front #(
  parameter int unsigned MAX_K         = 32,
  parameter int unsigned POSITION_BITS = 32
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  kkey_pkg::cfg_t    cfg_i,
  input  wire               klen_wr_i,
  input  wire               in_valid_i,
  output logic              in_stall_o,
  input  wire  [7:0]        text_byte_i,
  input  wire               q_full_i,
  output logic              push_o,
  output kkey_pkg::job_t    job_o
);
  import kkey_pkg::*;

  localparam int unsigned PB = POSITION_BITS;

  logic [WIN_W-1:0] fw_q, fw_d, rv_q, rv_d, mask, fw_sh, rv_sh;
  logic [5:0]       run_q, run_d, k;
  logic [PB-1:0]    cnt_q, cnt_d, diff;
  logic [PB+31:0]   diff_ext;
  logic             lstart_q, lstart_d, hdr_q, hdr_d;
  logic             accept, hdr_eff, is_base, emit;
  logic [2:0]       code;
  logic [1:0]       cb;

  assign accept     = in_valid_i && !q_full_i;
  assign in_stall_o = q_full_i;

  always_comb begin
    k = cfg_i.klen;
    if (k == 6'd0) k = 6'd1;
    if (k > 6'(MAX_K)) k = 6'(MAX_K);
  end

  always_comb begin
    unique case (text_byte_i)
      "A", "a": code = CODE_A;
      "C", "c": code = (cfg_i.mode == BIS_C2T) ? CODE_T : CODE_C;
      "G", "g": code = (cfg_i.mode == BIS_G2A) ? CODE_A : CODE_G;
      "T", "t": code = CODE_T;
      default:  code = CODE_N;
    endcase
  end

  assign cb      = code[1:0];
  assign hdr_eff = lstart_q ? (text_byte_i == BYTE_HDR) : hdr_q;
  assign is_base = (text_byte_i != BYTE_NL) && !hdr_eff && (text_byte_i >= BYTE_PRINT);

  always_comb begin
    fw_sh = {fw_q[WIN_W-3:0], cb};
    rv_sh = {2'b00, rv_q[WIN_W-1:2]};
    for (int i = 0; i < WIN_W / 2; i++) begin
      mask[2*i +: 2] = (6'(i) < k) ? 2'b11 : 2'b00;
      if (6'(i) == k - 6'd1) rv_sh[2*i +: 2] = ~cb;
    end
  end

  always_comb begin
    fw_d     = fw_q;
    rv_d     = rv_q;
    run_d    = run_q;
    cnt_d    = cnt_q;
    lstart_d = lstart_q;
    hdr_d    = hdr_q;
    emit     = 1'b0;
    if (accept) begin
      if (text_byte_i == BYTE_NL) begin
        lstart_d = 1'b1;
        hdr_d    = 1'b0;
      end else begin
        lstart_d = 1'b0;
        hdr_d    = hdr_eff;
      end
      if (is_base) begin
        if (cnt_q != {PB{1'b1}}) cnt_d = cnt_q + PB'(1);
        if (code == CODE_N) begin
          fw_d  = '0;
          rv_d  = '0;
          run_d = '0;
        end else begin
          fw_d = fw_sh & mask;
          rv_d = rv_sh & mask;
          if (run_q < k) run_d = run_q + 6'd1;
          emit = (run_d >= k);
        end
      end
    end
    if (klen_wr_i) begin
      fw_d  = '0;
      rv_d  = '0;
      run_d = '0;
    end
  end

  assign diff     = cnt_q - PB'(k - 6'd1);
  assign diff_ext = {32'b0, diff};

  assign push_o      = emit;
  assign job_o.canon = (fw_d < rv_d) ? fw_d : rv_d;
  assign job_o.fwd   = (fw_d < rv_d);
  assign job_o.start = diff_ext[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q     <= '0;
      rv_q     <= '0;
      run_q    <= '0;
      cnt_q    <= '0;
      lstart_q <= 1'b1;
      hdr_q    <= 1'b0;
    end else begin
      fw_q     <= fw_d;
      rv_q     <= rv_d;
      run_q    <= run_d;
      cnt_q    <= cnt_d;
      lstart_q <= lstart_d;
      hdr_q    <= hdr_d;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/kkey_fifo.sv
// Two-entry job queue between front end and remainder unit.
// Depends on kkey_pkg and the assertion macros.
`default_nettype none
`include "canonical_kmer_key_stream_core_macros.svh"
module kkey_fifo (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             push_i,
  input  kkey_pkg::job_t  job_i,
  output logic            full_o,
  input  wire             pop_i,
  output logic            valid_o,
  output kkey_pkg::job_t  job_o
);
  import kkey_pkg::*;

  localparam int unsigned DEPTH = 2;
  localparam int unsigned AW    = $clog2(DEPTH);

  job_t            mem_q [DEPTH];
  logic [AW-1:0]   wp_q, rp_q;
  logic [AW:0]     cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == (AW+1)'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rp_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wp_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wp_q <= wp_q + AW'(1);
      if (do_pop)  rp_q <= rp_q + AW'(1);
      cnt_q <= cnt_q + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end

  `KKEY_ASSERT(a_fifo_bound, clk_i, rst_ni, cnt_q <= (AW+1)'(DEPTH), "fifo over depth")
  `KKEY_ASSERT(a_fifo_nodrop, clk_i, rst_ni, !(push_i && full_o), "push into full fifo")

endmodule
`default_nettype wire

FILE: rtl/core/kkey_div.sv
// Back end: bit-serial remainder unit and output register.
// Depends on kkey_pkg and the assertion macros.
`default_nettype none
`include "canonical_kmer_key_stream_core_macros.svh"
module kkey_div (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire  [kkey_pkg::MOD_W-1:0]   mod_i,
  input  wire                          q_valid_i,
  input  kkey_pkg::job_t               job_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output logic [kkey_pkg::KEY_W-1:0]   bucket_key_o,
  output logic [kkey_pkg::WIN_W-1:0]   canonical_kmer_o,
  output logic                         forward_strand_o,
  output logic [kkey_pkg::KEY_W-1:0]   start_position_o
);
  import kkey_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]       st_q;
  logic [5:0]       step_q;
  job_t             job_q;
  logic [WIN_W-1:0] sh_q;
  logic [MOD_W-1:0] mod_q, rem_q;
  logic [MOD_W:0]   trial, diffv;
  logic             ge, out_free, out_valid_q;

  assign out_free = !out_valid_q || !out_stall_i;
  assign pop_o    = (st_q == ST_IDLE) && q_valid_i;
  assign trial    = {rem_q, sh_q[WIN_W-1]};
  assign ge       = trial >= {1'b0, mod_q};
  assign diffv    = trial - {1'b0, mod_q};
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i) begin
    priority if (pop_o) begin
      job_q <= job_i;
      sh_q  <= job_i.canon;
      mod_q <= mod_i;
      rem_q <= '0;
    end else if (st_q == ST_DIV) begin
      sh_q  <= {sh_q[WIN_W-2:0], 1'b0};
      rem_q <= ge ? diffv[MOD_W-1:0] : trial[MOD_W-1:0];
    end
    if (st_q == ST_DONE && out_free) begin
      bucket_key_o     <= (mod_q == '0) ? job_q.canon[KEY_W-1:0] : rem_q[KEY_W-1:0];
      canonical_kmer_o <= job_q.canon;
      forward_strand_o <= job_q.fwd;
      start_position_o <= job_q.start;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (st_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (st_q)
        ST_IDLE: begin
          step_q <= '0;
          if (q_valid_i) st_q <= ST_DIV;
        end
        ST_DIV: begin
          step_q <= step_q + 6'd1;
          if (step_q == 6'd63) st_q <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) st_q <= ST_IDLE;
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  `KKEY_ASSERT(a_rem_lt_mod, clk_i, rst_ni,
    !(st_q == ST_DIV && mod_q != '0) || (rem_q < mod_q), "remainder not below modulus")
  `KKEY_ASSERT_NEXT(a_done_loads, clk_i, rst_ni, st_q == ST_DONE && out_free,
    out_valid_q && st_q == ST_IDLE, "finished job not handed to output")
  `KKEY_ASSERT(a_pop_idle, clk_i, rst_ni, !pop_o || q_valid_i, "pop from empty queue")

endmodule
`default_nettype wire

FILE: rtl/core/canonical_kmer_key_stream_core.sv
// Canonical k-mer key stream core. Text bytes are accepted one per cycle
// while the two-entry job queue has room; while it is full every byte waits,
// whether or not it ends a k-mer. Each emitted k-mer goes through the
// remainder unit (one load, 64 shift/subtract steps, one hand-off into the
// output register), which takes no new k-mer until the last is handed off.
// Depends on kkey_pkg, kkey_front, kkey_fifo and kkey_div.
`default_nettype none
module canonical_kmer_key_stream_core #(
  parameter int unsigned MAX_K         = 32,
  parameter int unsigned POSITION_BITS = 32
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire  [1:0]                   cfg_index_i,
  input  wire  [kkey_pkg::MOD_W-1:0]   cfg_data_i,
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  wire  [7:0]                   text_byte_i,
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output logic [kkey_pkg::KEY_W-1:0]   bucket_key_o,
  output logic [kkey_pkg::WIN_W-1:0]   canonical_kmer_o,
  output logic                         forward_strand_o,
  output logic [kkey_pkg::KEY_W-1:0]   start_position_o
);
  import kkey_pkg::*;

  cfg_t             cfg_q;
  logic [MOD_W-1:0] mod_q;
  logic             klen_wr, q_full, push, q_valid, pop;
  job_t             push_job, pop_job;

  assign klen_wr = cfg_we_i && (cfg_index_i == CFG_KLEN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.klen <= 6'd32;
      cfg_q.mode <= 2'd0;
      mod_q      <= MOD_W'(536870911);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_KLEN: cfg_q.klen <= cfg_data_i[5:0];
        CFG_MOD:  mod_q      <= cfg_data_i;
        CFG_BIS:  cfg_q.mode <= cfg_data_i[1:0];
        default:  ;
      endcase
    end
  end

  kkey_front #(
    .MAX_K         (MAX_K),
    .POSITION_BITS (POSITION_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .klen_wr_i   (klen_wr),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .text_byte_i (text_byte_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .job_o       (push_job)
  );

  kkey_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .job_o   (pop_job)
  );

  kkey_div u_div (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .mod_i            (mod_q),
    .q_valid_i        (q_valid),
    .job_i            (pop_job),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .bucket_key_o     (bucket_key_o),
    .canonical_kmer_o (canonical_kmer_o),
    .forward_strand_o (forward_strand_o),
    .start_position_o (start_position_o)
  );

endmodule
`default_nettype wire

FILE: sim/tb_canonical_kmer_key_stream_core.sv
// Testbench for canonical_kmer_key_stream_core: drives text bytes, checks each emitted
// k-mer result against a table or an in-bench predictor of windows, positions and keys.
// Depends on kkey_pkg and the core RTL.
`timescale 1ns / 1ps
module tb_canonical_kmer_key_stream_core;
  import kkey_pkg::*;

  localparam int unsigned LIMIT = 2000000;
  localparam int unsigned SETTLE = 150;

  typedef struct {
    logic [31:0] key;
    logic [63:0] canon;
    logic        fwd;
    logic [31:0] start;
  } kmer_res_t;

  typedef struct {
    logic [7:0] text;
    bit         typed;
    kmer_res_t  res;
  } text_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [32:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  text_byte_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] bucket_key_o;
  logic [63:0] canonical_kmer_o;
  logic        forward_strand_o;
  logic [31:0] start_position_o;

  canonical_kmer_key_stream_core dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // predictor state
  logic [5:0]  klen_reg;
  logic [32:0] modulus_reg;
  logic [1:0]  mode_reg;
  logic [63:0] fwd_win, rev_win;
  int unsigned clean_bases;
  logic [32:0] base_pos;
  bit          line_start, header_line;

  kmer_res_t   kmer_q[$];
  int unsigned errors = 0;
  int unsigned kmers_seen = 0;
  int unsigned bytes_sent = 0;
  int unsigned cycles = 0;
  bit          quiet = 1'b0;

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %h want %h (result %0d)", what, got, want, kmers_seen);
    errors++;
  endtask

  function automatic logic [2:0] base_of(logic [7:0] b);
    case (b)
      "A", "a": return CODE_A;
      "C", "c": return (mode_reg == BIS_C2T) ? CODE_T : CODE_C;
      "G", "g": return (mode_reg == BIS_G2A) ? CODE_A : CODE_G;
      "T", "t": return CODE_T;
      default:  return CODE_N;
    endcase
  endfunction

  task automatic apply_cfg(logic [1:0] idx, logic [32:0] val);
    if (idx == CFG_KLEN) begin
      klen_reg = val[5:0];
      fwd_win = '0;
      rev_win = '0;
      clean_bases = 0;
    end else if (idx == CFG_MOD) begin
      modulus_reg = val;
    end else if (idx == CFG_BIS) begin
      mode_reg = val[1:0];
    end
  endtask

  // advance the predictor by one byte; returns 1 with a result when a k-mer ends
  function automatic bit kmer_step(logic [7:0] b, output kmer_res_t r);
    int unsigned k;
    logic [2:0]  code;
    logic [63:0] mask, canon;
    logic [32:0] pos;
    r = '{default: '0};
    if (b == BYTE_NL) begin
      line_start = 1'b1;
      header_line = 1'b0;
      return 0;
    end
    if (line_start) begin
      line_start = 1'b0;
      if (b == BYTE_HDR) header_line = 1'b1;
    end
    if (header_line || b < BYTE_PRINT) return 0;
    k = (klen_reg == 0) ? 1 : (klen_reg > 32) ? 32 : klen_reg;
    code = base_of(b);
    pos = base_pos;
    if (base_pos < 33'hFFFF_FFFF) base_pos++;
    if (code == CODE_N) begin
      clean_bases = 0;
      fwd_win = '0;
      rev_win = '0;
      return 0;
    end
    mask = (k >= 32) ? '1 : ((64'd1 << (2 * k)) - 64'd1);
    fwd_win = ((fwd_win << 2) | 64'(code)) & mask;
    rev_win = ((rev_win >> 2) | (64'(3 ^ code) << (2 * (k - 1)))) & mask;
    if (clean_bases < k) clean_bases++;
    if (clean_bases < k) return 0;
    canon = (fwd_win < rev_win) ? fwd_win : rev_win;
    r.canon = canon;
    r.fwd = fwd_win < rev_win;
    r.key = (modulus_reg == 0) ? canon[31:0] : 32'(canon % 64'(modulus_reg));
    r.start = 32'(pos - 33'(k - 1));
    return 1;
  endfunction

  task automatic send_text(logic [7:0] b, bit typed, kmer_res_t want);
    kmer_res_t r;
    if (!quiet && $urandom_range(0, 99) < 33) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    text_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    bytes_sent++;
    if (kmer_step(b, r)) kmer_q = {kmer_q, (typed ? want : r)};
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    wait (kmer_q.size() == 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [32:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    apply_cfg(idx, val);
  endtask

  function automatic logic [7:0] rand_text();
    int unsigned sel = $urandom_range(0, 99);
    string bases = "ACGTacgt";
    if (sel < 72) return bases[$urandom_range(0, 7)];
    if (sel < 78) return BYTE_NL;
    if (sel < 82) return BYTE_HDR;
    if (sel < 94) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, 32));
  endfunction

  always @(posedge clk_i) begin
    kmer_res_t w;
    cycles++;
    if (cycles > LIMIT) begin
      $display("canonical_kmer_key_stream_core test failed");
      $finish;
    end
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        kmers_seen++;
        if (kmer_q.size() == 0) begin
          report("unexpected result", canonical_kmer_o, '0);
        end else begin
          w = kmer_q.pop_front();
          if (bucket_key_o !== w.key) report("bucket_key", bucket_key_o, w.key);
          if (canonical_kmer_o !== w.canon) report("canonical_kmer", canonical_kmer_o, w.canon);
          if (forward_strand_o !== w.fwd) report("forward_strand", forward_strand_o, w.fwd);
          if (start_position_o !== w.start)
            report("start_position", start_position_o, w.start);
        end
      end
      out_stall_i <= !quiet && ($urandom_range(0, 99) < 33);
    end
  end

  text_row_t rows[24] = '{
    '{"A", 1, '{32'd0, 64'd0, 1'b1, 32'd0}},
    '{"T", 1, '{32'd0, 64'd0, 1'b0, 32'd1}},
    '{"C", 1, '{32'd1, 64'd1, 1'b1, 32'd2}},
    '{"G", 1, '{32'd1, 64'd1, 1'b0, 32'd3}},
    '{"N", 0, '{default: '0}},
    '{8'hFF, 0, '{default: '0}},
    '{8'h00, 0, '{default: '0}},
    '{8'd32, 0, '{default: '0}},
    '{8'd10, 0, '{default: '0}},
    '{">", 0, '{default: '0}},
    '{"A", 0, '{default: '0}},
    '{8'd10, 0, '{default: '0}},
    '{"g", 1, '{32'd1, 64'd1, 1'b0, 32'd6}},
    '{"a", 0, '{default: '0}},
    '{"c", 0, '{default: '0}},
    '{"t", 0, '{default: '0}},
    '{"!", 0, '{default: '0}},
    '{8'd127, 0, '{default: '0}},
    '{8'h80, 0, '{default: '0}},
    '{"T", 0, '{default: '0}},
    '{8'd10, 0, '{default: '0}},
    '{"C", 0, '{default: '0}},
    '{"~", 0, '{default: '0}},
    '{"G", 0, '{default: '0}}
  };

  logic [5:0]  klen_set[8] = '{6'd3, 6'd32, 6'd0, 6'd63, 6'd5, 6'd1, 6'd12, 6'd31};
  logic [32:0] mod_set[8]  = '{33'd1, 33'h1_0000_0000, 33'd0, 33'd536870911,
                               33'd97, 33'hFFFF_FFFF, 33'd2, 33'd65521};
  logic [1:0]  mode_set[8] = '{2'd1, 2'd2, 2'd3, 2'd0, 2'd1, 2'd0, 2'd2, 2'd0};

  initial begin
    kmer_res_t none;
    none = '{default: '0};
    klen_reg = 6'd32;
    modulus_reg = 33'd536870911;
    mode_reg = '0;
    fwd_win = '0;
    rev_win = '0;
    clean_bases = 0;
    base_pos = '0;
    line_start = 1'b1;
    header_line = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    write_cfg(CFG_KLEN, 33'd1);
    write_cfg(CFG_MOD, 33'd0);
    write_cfg(CFG_BIS, 33'd0);
    cfg_we_i <= 1'b0;
    foreach (rows[i]) send_text(rows[i].text, rows[i].typed, rows[i].res);
    drain();

    for (int p = 0; p < 8; p++) begin
      write_cfg(CFG_KLEN, 33'(klen_set[p]));
      write_cfg(CFG_MOD, mod_set[p]);
      write_cfg(CFG_BIS, 33'(mode_set[p]));
      cfg_we_i <= 1'b0;
      quiet = (p == 3);
      for (int i = 0; i < 130; i++) begin
        // hold off until the core has emptied once
        if (p == 5 && i == 60) begin
          in_valid_i <= 1'b0;
          @(posedge clk_i);
          wait (kmer_q.size() == 0);
        end
        send_text(rand_text(), 0, none);
      end
      quiet = 1'b0;
      drain();
    end

    $display("Sent %0d text bytes over 9 settings of length, modulus and mode;",
             bytes_sent);
    $display("checked %0d k-mer results, %0d mismatches.", kmers_seen, errors);
    if (errors == 0 && kmer_q.size() == 0) begin
      $display("canonical_kmer_key_stream_core test passed");
    end else begin
      $display("canonical_kmer_key_stream_core test failed");
    end
    $finish;
  end

endmodule
